@@ design/sync_frame_status_parser_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sync frame status parser
// Concurrent checks clocked on clk; they compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAME_STATUS_PARSER_ASSERT_SVH
`define SYNC_FRAME_STATUS_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every rising clk edge outside reset.
`define SFSP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define SFSP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SFSP_ASSERT(lbl, prop, msg)
`define SFSP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ design/sfsp_pkg.sv @@
// ----------------------------------------------------------------------------
// sfsp_pkg
// Frame codes, parser states and shared types for the frame status parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfsp_pkg;

    localparam logic [7:0] HDR_FIRST   = 8'h55;
    localparam logic [7:0] HDR_SECOND  = 8'hAA;
    localparam logic [7:0] TRL_FIRST   = 8'h0D;
    localparam logic [7:0] TRL_SECOND  = 8'h0A;
    localparam logic [7:0] ST_STEPPING = 8'hAA;
    localparam logic [7:0] ST_DONE     = 8'hFF;

    // Position within the frame: the number of frame bytes held so far.
    typedef enum logic [2:0] {
        FS_HUNT    = 3'd0,
        FS_HDR2    = 3'd1,
        FS_STATUS  = 3'd2,
        FS_RESERVE = 3'd3,
        FS_CHECK   = 3'd4,
        FS_TRL1    = 3'd5,
        FS_TRL2    = 3'd6
    } frame_state_t;

    // Result handed from the frame tracker to the output register.
    typedef struct packed {
        logic valid;
        logic gait_run;
    } res_t;

endpackage

`default_nettype wire

@@ design/sfsp_rx_if.sv @@
// ----------------------------------------------------------------------------
// sfsp_rx_if
// Valid/ready channel that carries one received serial byte per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sfsp_rx_if;

    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);

endinterface

`default_nettype wire

@@ design/sfsp_res_if.sv @@
// ----------------------------------------------------------------------------
// sfsp_res_if
// Valid/ready channel that carries one decoded frame status per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sfsp_res_if;

    logic valid;
    logic ready;
    logic gait_run;

    modport source (output valid, output gait_run, input ready);
    modport sink (input valid, input gait_run, output ready);

endinterface

`default_nettype wire

@@ design/sfsp_frame_tracker.sv @@
// ----------------------------------------------------------------------------
// sfsp_frame_tracker
// Input byte register, frame position state machine and frame check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfsp_frame_tracker (
    input  wire logic    clk,
    input  wire logic    rst_n,
    sfsp_rx_if.sink      rx,
    input  wire logic    slot_free,
    output sfsp_pkg::res_t res
);

    import sfsp_pkg::*;

    logic         in_vld_reg;
    logic [7:0]   in_byte_reg;
    frame_state_t state_reg;
    frame_state_t state_next;
    logic [7:0]   status_reg;
    logic [7:0]   reserve_reg;
    logic [7:0]   check_reg;
    logic         trl_ok_reg;
    logic [7:0]   sum;
    logic         hit;
    logic         advance;

    // A byte with no result may always move on; a frame hit needs a free slot.
    assign sum     = status_reg + reserve_reg;
    assign hit     = (state_reg == FS_TRL2) && trl_ok_reg && (in_byte_reg == TRL_SECOND)
                     && (sum == check_reg)
                     && ((status_reg == ST_STEPPING) || (status_reg == ST_DONE));
    assign advance = in_vld_reg && (!hit || slot_free);
    assign rx.ready = !in_vld_reg || advance;

    assign res.valid    = advance && hit;
    assign res.gait_run = (status_reg == ST_STEPPING);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            state_reg  <= FS_HUNT;
        end
        else
        begin
            if (rx.valid && rx.ready)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
            in_byte_reg <= rx.rx_byte;
        if (advance)
        begin
            if (state_reg == FS_STATUS)
                status_reg <= in_byte_reg;
            if (state_reg == FS_RESERVE)
                reserve_reg <= in_byte_reg;
            if (state_reg == FS_CHECK)
                check_reg <= in_byte_reg;
            if (state_reg == FS_TRL1)
                trl_ok_reg <= (in_byte_reg == TRL_FIRST);
        end
    end

    always_comb
    begin
        case (state_reg)
            FS_HDR2:    state_next = (in_byte_reg == HDR_SECOND) ? FS_STATUS : FS_HUNT;
            FS_STATUS:  state_next = FS_RESERVE;
            FS_RESERVE: state_next = FS_CHECK;
            FS_CHECK:   state_next = FS_TRL1;
            FS_TRL1:    state_next = FS_TRL2;
            FS_TRL2:    state_next = FS_HUNT;
            default:    state_next = (in_byte_reg == HDR_FIRST) ? FS_HDR2 : FS_HUNT;
        endcase
    end

endmodule

`default_nettype wire

@@ design/sfsp_result_reg.sv @@
// ----------------------------------------------------------------------------
// sfsp_result_reg
// Output register that holds one decoded status until the sink takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sfsp_result_reg (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire sfsp_pkg::res_t res,
    output logic          slot_free,
    sfsp_res_if.source    result
);

    import sfsp_pkg::*;

    logic out_vld_reg;
    logic out_stp_reg;

    assign slot_free       = !out_vld_reg || result.ready;
    assign result.valid    = out_vld_reg;
    assign result.gait_run = out_stp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (res.valid)
            out_vld_reg <= 1'b1;
        else if (result.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
            out_stp_reg <= res.gait_run;
    end

endmodule

`default_nettype wire

@@ design/sync_frame_status_parser.sv @@
// ----------------------------------------------------------------------------
// sync_frame_status_parser
// Hunts for 55 AA status reserve check 0D 0A frames in a received byte stream
// and reports the gait status of each good frame.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload              Request
//   rx       in         rx_byte [7:0]        one received serial byte
//   result   out        gait_run [0:0]       status of one good frame
//
// The block takes one byte per cycle while no frame-completing byte waits. A
// byte is held in the input register, where the frame state machine and the
// checksum compare act on it, and a frame's result moves to the output register.
// Reset clears the frame state and both valid flags, so the block starts hunting.
// While a result waits in the output register, bytes without a result keep
// flowing; only a frame-completing byte waits for the output register to empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sync_frame_status_parser_assert.svh"

module sync_frame_status_parser (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sfsp_rx_if.sink    rx,
    sfsp_res_if.source result
);

    import sfsp_pkg::*;

    // Result of the byte leaving the input register this cycle.
    res_t res;
    // High when the output register can take a new result this cycle.
    logic slot_free;

    // The tracker owns the input register, the frame position and the stored
    // status, reserve and check bytes. It only retires a frame-completing
    // byte when the output register has room.
    sfsp_frame_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .slot_free (slot_free),
        .res       (res)
    );

    // The output register decouples the sink's ready from the byte stream.
    sfsp_result_reg u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .slot_free (slot_free),
        .result    (result)
    );

    // A new result must never overwrite one the sink has not taken.
    `SFSP_ASSERT(a_no_overwrite, res.valid |-> slot_free, "result written into a full slot")
    // Every produced result shows up on the output the next cycle.
    `SFSP_ASSERT(a_res_shown, res.valid |=> result.valid, "produced result not presented")
    // The presented status is the one the tracker decoded.
    `SFSP_ASSERT(a_res_value, res.valid |=> (result.gait_run == $past(res.gait_run)), "status differs")

endmodule

`default_nettype wire
